@@ rtl/core/i64alu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64alu_pkg
// Types and operation codes shared by the 64-bit integer ALU modules.
// ----------------------------------------------------------------------------
package i64alu_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned ShiftW = 6;
  localparam int unsigned OpW    = 4;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_AND = 4'd2,
    OP_OR  = 4'd3,
    OP_XOR = 4'd4,
    OP_SHL = 4'd5,
    OP_SHR = 4'd6,
    OP_LT  = 4'd7,
    OP_MUL = 4'd8,
    OP_DIV = 4'd9
  } op_e;

  // back-end work class chosen by the front end
  typedef enum logic [1:0] {
    CLS_DONE = 2'd0,
    CLS_MUL  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_e;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [DataW-1:0]  operand_a;
    logic [DataW-1:0]  operand_b;
    logic [ShiftW-1:0] shift_amount;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             divide_by_zero;
  } out_item_t;

  // classified transaction passed from front to back
  typedef struct packed {
    cls_e             cls;
    logic [DataW-1:0] value;
    logic [DataW-1:0] opnd_a;
    logic [DataW-1:0] opnd_b;
    logic             dz;
  } work_t;

endpackage

@@ rtl/core/int64_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_alu
// Unsigned 64-bit ALU with queue-style ports.
// ----------------------------------------------------------------------------
// A front stage decodes each transaction and finishes add, sub, logic,
// shifts and compare there; a one-entry register hands it to the back end.
// The back end holds one transaction: a simple operation goes straight to
// the result register, multiply sums three 32x32 partial products through
// one multiplier, one per cycle, and divide runs the restoring divider, one
// quotient bit per cycle. The result register then holds until popped and
// the back end takes the next transaction the cycle after the pop; the front
// keeps one more transaction waiting meanwhile.
module int64_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  i64alu_pkg::in_item_t  in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output i64alu_pkg::out_item_t out_item_o
);

  logic              in_ready, wk_valid, wk_ready, res_valid;
  i64alu_pkg::work_t wk;

  assign full  = !in_ready;
  assign empty = !res_valid;

  i64alu_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(push), .in_ready_o(in_ready), .in_item_i(in_item_i),
    .wk_valid_o(wk_valid), .wk_ready_i(wk_ready), .wk_o(wk)
  );

  i64alu_back u_back (
    .clk_i, .rst_ni,
    .wk_valid_i(wk_valid), .wk_ready_o(wk_ready), .wk_i(wk),
    .res_valid_o(res_valid), .res_ready_i(pop), .res_o(out_item_o)
  );

endmodule

@@ rtl/core/i64alu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64alu_front
// Decodes a transaction, finishes add, sub, logic, shift and compare, and registers it.
// ----------------------------------------------------------------------------
module i64alu_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  i64alu_pkg::in_item_t in_item_i,
  output logic                 wk_valid_o,
  input  logic                 wk_ready_i,
  output i64alu_pkg::work_t    wk_o
);

  logic              valid_q;
  i64alu_pkg::work_t wk_q, wk_d;

  assign in_ready_o = !valid_q || wk_ready_i;
  assign wk_valid_o = valid_q;
  assign wk_o       = wk_q;

  always_comb begin
    wk_d        = '0;
    wk_d.cls    = i64alu_pkg::CLS_DONE;
    wk_d.opnd_a = in_item_i.operand_a;
    wk_d.opnd_b = in_item_i.operand_b;
    unique case (in_item_i.operation)
      i64alu_pkg::OP_ADD: wk_d.value = in_item_i.operand_a + in_item_i.operand_b;
      i64alu_pkg::OP_SUB: wk_d.value = in_item_i.operand_a - in_item_i.operand_b;
      i64alu_pkg::OP_AND: wk_d.value = in_item_i.operand_a & in_item_i.operand_b;
      i64alu_pkg::OP_OR:  wk_d.value = in_item_i.operand_a | in_item_i.operand_b;
      i64alu_pkg::OP_XOR: wk_d.value = in_item_i.operand_a ^ in_item_i.operand_b;
      i64alu_pkg::OP_SHL: wk_d.value = in_item_i.operand_a << in_item_i.shift_amount;
      i64alu_pkg::OP_SHR: wk_d.value = in_item_i.operand_a >> in_item_i.shift_amount;
      i64alu_pkg::OP_LT: begin
        wk_d.value = {{(i64alu_pkg::DataW-1){1'b0}},
                      (in_item_i.operand_a < in_item_i.operand_b)};
      end
      i64alu_pkg::OP_MUL: wk_d.cls = i64alu_pkg::CLS_MUL;
      i64alu_pkg::OP_DIV: begin
        if (in_item_i.operand_b == '0) begin
          wk_d.dz = 1'b1;
        end else begin
          wk_d.cls = i64alu_pkg::CLS_DIV;
        end
      end
      default: wk_d.value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      wk_q <= wk_d;
    end
  end

endmodule

@@ rtl/core/i64alu_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64alu_back
// Multiply (32x32 partial products), restoring divide and result pass-through.
// ----------------------------------------------------------------------------
module i64alu_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wk_valid_i,
  output logic                  wk_ready_o,
  input  i64alu_pkg::work_t     wk_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output i64alu_pkg::out_item_t res_o
);

  localparam int unsigned DW = i64alu_pkg::DataW;
  localparam int unsigned HW = i64alu_pkg::HalfW;
  localparam int unsigned CntW = $clog2(DW);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [DW-1:0]     a_q, a_d, b_q, b_d, rem_q, rem_d, acc_q, acc_d;
  logic [1:0]        mstep_q, mstep_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              dz_q, dz_d;
  logic [2*HW-1:0]   pp;
  logic [HW-1:0]     pa, pb;
  logic [DW:0]       shifted, diff;

  assign wk_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);
  assign res_o.result_value   = acc_q;
  assign res_o.divide_by_zero = dz_q;

  // one 32x32 partial product per step: lo*lo, lo*hi, hi*lo
  always_comb begin
    pa = a_q[HW-1:0];
    pb = b_q[HW-1:0];
    unique case (mstep_q)
      2'd1:    pb = b_q[DW-1:HW];
      2'd2:    pa = a_q[DW-1:HW];
      default: ;
    endcase
  end
  assign pp = pa * pb;

  assign shifted = {rem_q, a_q[DW-1]};
  assign diff    = shifted - {1'b0, b_q};

  always_comb begin
    state_d = state_q;
    a_d = a_q; b_d = b_q; rem_d = rem_q; acc_d = acc_q;
    mstep_d = mstep_q; cnt_d = cnt_q; dz_d = dz_q;
    unique case (state_q)
      ST_IDLE: begin
        if (wk_valid_i) begin
          a_d = wk_i.opnd_a; b_d = wk_i.opnd_b;
          dz_d = wk_i.dz; mstep_d = 2'd0; cnt_d = '0;
          rem_d = '0; acc_d = wk_i.value;
          unique case (wk_i.cls)
            i64alu_pkg::CLS_MUL: begin
              acc_d = '0; state_d = ST_MUL;
            end
            i64alu_pkg::CLS_DIV: begin
              acc_d = '0; state_d = ST_DIV;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_MUL: begin
        unique case (mstep_q)
          2'd0:    acc_d = acc_q + pp;
          default: acc_d = acc_q + {pp[HW-1:0], {HW{1'b0}}};
        endcase
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd2) state_d = ST_OUT;
      end
      ST_DIV: begin
        // shift in next dividend bit, subtract when it fits
        a_d = {a_q[DW-2:0], 1'b0};
        if (!diff[DW]) begin
          rem_d = diff[DW-1:0];
          acc_d = {acc_q[DW-2:0], 1'b1};
        end else begin
          rem_d = shifted[DW-1:0];
          acc_d = {acc_q[DW-2:0], 1'b0};
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DW-1)) state_d = ST_OUT;
      end
      ST_OUT: if (res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; rem_q <= rem_d; acc_q <= acc_d;
    mstep_q <= mstep_d; cnt_q <= cnt_d; dz_q <= dz_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("back state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CntW'(DW-1)) |=> state_q == ST_OUT)
    else $error("divide did not finish after last step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !res_ready_i) |=> state_q == ST_OUT && $stable(acc_q))
    else $error("result changed while stalled");

endmodule
